// File: hw/rtl/assert_macros.svh
// assertion macros shared by the blitter rtl
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: always");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/nnsb_pkg.sv
// types and constants of the nearest-neighbor scale blitter
// no dependencies; imported by nnsb_cfg, nnsb_front, nnsb_back and the top level
package nnsb_pkg;

  localparam int INT_BITS   = 12;
  localparam int MAX_DIM    = 4096;
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int ADDR_W     = 26;
  localparam int STEP_W     = 20;
  localparam int PITCH_W    = 15;
  localparam int DIM_W      = 13;
  localparam int BPP_W      = 3;
  localparam int PIX_W      = 32;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 3;

  localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;
  localparam logic [BPP_W-1:0] BPP_WIDE     = 3'd4;

  // reset values of the configuration registers
  localparam logic [STEP_W-1:0]  X_STEP_RST     = 20'd65536;
  localparam logic [STEP_W-1:0]  Y_STEP_RST     = 20'd65536;
  localparam logic [PITCH_W-1:0] SRC_PITCH_RST  = 15'd1920;
  localparam logic [PITCH_W-1:0] DST_PITCH_RST  = 15'd2560;
  localparam logic [DIM_W-1:0]   DST_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]   DST_HEIGHT_RST = 13'd480;
  localparam logic [BPP_W-1:0]   SRC_BPP_RST    = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_STEP     = 3'd0,
    CFG_Y_STEP     = 3'd1,
    CFG_SRC_PITCH  = 3'd2,
    CFG_DST_PITCH  = 3'd3,
    CFG_DST_WIDTH  = 3'd4,
    CFG_DST_HEIGHT = 3'd5,
    CFG_SRC_BPP    = 3'd6,
    CFG_OUT_16BIT  = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_t;

  // configuration as seen by the datapath, dimensions already clamped
  typedef struct packed {
    logic [STEP_W-1:0]  x_step;
    logic [STEP_W-1:0]  y_step;
    logic [PITCH_W-1:0] src_pitch;
    logic [PITCH_W-1:0] dst_pitch;
    logic [IDX_W-1:0]   w_m1;
    logic [IDX_W-1:0]   h_m1;
    logic               bpp4;
    logic               out16;
  } cfg_t;

  // classified item passed from front to back
  typedef struct packed {
    logic                fetch_valid;
    logic [INT_BITS-1:0] sx;
    logic [INT_BITS-1:0] sy;
    logic                pixel_valid;
    logic [IDX_W-1:0]    flipped;
    logic [IDX_W-1:0]    col;
    logic [PIX_W-1:0]    packed_pixel;
    logic                last;
  } mid_item_t;

  // finished result item
  typedef struct packed {
    logic              fetch_valid;
    logic [ADDR_W-1:0] fetch_addr;
    logic              pixel_valid;
    logic [ADDR_W-1:0] write_addr;
    logic [PIX_W-1:0]  packed_pixel;
    logic              frame_last;
  } res_item_t;

endpackage

// File: hw/rtl/nnsb_fifo.sv
// small register queue with push/full and pop/empty sides
// no package dependencies
module nnsb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count, pointers wrap at the last entry
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/nnsb_cfg.sv
// configuration registers and derived datapath settings
// depends on nnsb_pkg
module nnsb_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [nnsb_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [nnsb_pkg::CFG_DATA_W-1:0] cfg_data,
  output nnsb_pkg::cfg_t                 cfg
);
  import nnsb_pkg::*;

  logic [STEP_W-1:0]  x_step;
  logic [STEP_W-1:0]  y_step;
  logic [PITCH_W-1:0] src_pitch;
  logic [PITCH_W-1:0] dst_pitch;
  logic [DIM_W-1:0]   dst_width;
  logic [DIM_W-1:0]   dst_height;
  logic [BPP_W-1:0]   src_bpp;
  logic               out16;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      x_step     <= X_STEP_RST;
      y_step     <= Y_STEP_RST;
      src_pitch  <= SRC_PITCH_RST;
      dst_pitch  <= DST_PITCH_RST;
      dst_width  <= DST_WIDTH_RST;
      dst_height <= DST_HEIGHT_RST;
      src_bpp    <= SRC_BPP_RST;
      out16      <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_X_STEP:     x_step     <= cfg_data[STEP_W-1:0];
        CFG_Y_STEP:     y_step     <= cfg_data[STEP_W-1:0];
        CFG_SRC_PITCH:  src_pitch  <= cfg_data[PITCH_W-1:0];
        CFG_DST_PITCH:  dst_pitch  <= cfg_data[PITCH_W-1:0];
        CFG_DST_WIDTH:  dst_width  <= cfg_data[DIM_W-1:0];
        CFG_DST_HEIGHT: dst_height <= cfg_data[DIM_W-1:0];
        CFG_SRC_BPP:    src_bpp    <= cfg_data[BPP_W-1:0];
        CFG_OUT_16BIT:  out16      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp a dimension to [1, MAX_DIM] and return it minus one
  function automatic logic [IDX_W-1:0] dim_m1(input logic [DIM_W-1:0] d);
    logic [IDX_W-1:0] r;
    if (d == '0) begin
      r = '0;
    end else if (32'(d) > MAX_DIM) begin
      r = IDX_W'(MAX_DIM - 1);
    end else begin
      r = IDX_W'(d - 1'b1);
    end
    return r;
  endfunction

  // derived settings
  always_comb begin
    cfg.x_step    = x_step;
    cfg.y_step    = y_step;
    cfg.src_pitch = src_pitch;
    cfg.dst_pitch = dst_pitch;
    cfg.w_m1      = dim_m1(dst_width);
    cfg.h_m1      = dim_m1(dst_height);
    cfg.bpp4      = !out16 && (src_bpp == BPP_WIDE);
    cfg.out16     = out16;
  end

endmodule

// File: hw/rtl/nnsb_front.sv
// front end: accepts items, walks the raster and classifies each item
// depends on nnsb_pkg
module nnsb_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nnsb_pkg::cfg_t       cfg,
  input  logic                 accept,
  input  logic                 cmd,
  input  logic [7:0]           byte0,
  input  logic [7:0]           byte1,
  input  logic [7:0]           byte2,
  input  logic [7:0]           byte3,
  output nnsb_pkg::mid_item_t  item
);
  import nnsb_pkg::*;

  localparam int ACC_W = FRAC_BITS + INT_BITS;

  logic              active;
  logic              active_next;
  logic [IDX_W-1:0]  col;
  logic [IDX_W-1:0]  col_next;
  logic [IDX_W-1:0]  row;
  logic [IDX_W-1:0]  row_next;
  logic [ACC_W-1:0]  x_acc;
  logic [ACC_W-1:0]  x_acc_next;
  logic [ACC_W-1:0]  y_acc;
  logic [ACC_W-1:0]  y_acc_next;

  logic [IDX_W-1:0]  col_g;
  logic [IDX_W-1:0]  row_g;
  logic              at_row_end;
  logic              at_last;
  logic [ACC_W-1:0]  x_sum;
  logic [ACC_W-1:0]  y_sum;
  logic [PIX_W-1:0]  pix;

  // clip the walk position if dimensions shrank mid-frame
  assign col_g      = (col > cfg.w_m1) ? cfg.w_m1 : col;
  assign row_g      = (row > cfg.h_m1) ? cfg.h_m1 : row;
  assign at_row_end = (col_g == cfg.w_m1);
  assign at_last    = at_row_end && (row_g == cfg.h_m1);
  assign x_sum      = x_acc + ACC_W'(cfg.x_step);
  assign y_sum      = y_acc + ACC_W'(cfg.y_step);

  // pixel packing, rgb555 from top five bits or argb8888
  always_comb begin
    if (cfg.out16) begin
      pix = {17'd0, byte2[7:3], byte1[7:3], byte0[7:3]};
    end else begin
      pix = {(cfg.bpp4 ? byte3 : ALPHA_OPAQUE), byte2, byte1, byte0};
    end
  end

  // walk state and classified item
  always_comb begin
    active_next = active;
    col_next    = col;
    row_next    = row;
    x_acc_next  = x_acc;
    y_acc_next  = y_acc;
    item        = '0;
    if (accept) begin
      if (cmd == CMD_START) begin
        active_next      = 1'b1;
        col_next         = '0;
        row_next         = '0;
        x_acc_next       = '0;
        y_acc_next       = '0;
        item.fetch_valid = 1'b1;
      end else if (active) begin
        item.pixel_valid  = 1'b1;
        item.flipped      = cfg.h_m1 - row_g;
        item.col          = col_g;
        item.packed_pixel = pix;
        item.last         = at_last;
        if (at_last) begin
          active_next = 1'b0;
          col_next    = '0;
          row_next    = '0;
          x_acc_next  = '0;
          y_acc_next  = '0;
        end else if (at_row_end) begin
          col_next         = '0;
          row_next         = row_g + 1'b1;
          x_acc_next       = '0;
          y_acc_next       = y_sum;
          item.fetch_valid = 1'b1;
          item.sy          = y_sum[FRAC_BITS +: INT_BITS];
        end else begin
          col_next         = col_g + 1'b1;
          row_next         = row_g;
          x_acc_next       = x_sum;
          item.fetch_valid = 1'b1;
          item.sx          = x_sum[FRAC_BITS +: INT_BITS];
          item.sy          = y_acc[FRAC_BITS +: INT_BITS];
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      col    <= '0;
      row    <= '0;
      x_acc  <= '0;
      y_acc  <= '0;
    end else begin
      active <= active_next;
      col    <= col_next;
      row    <= row_next;
      x_acc  <= x_acc_next;
      y_acc  <= y_acc_next;
    end
  end

endmodule

// File: hw/rtl/nnsb_back.sv
// back end: turns classified items into source and destination addresses
// depends on nnsb_pkg
module nnsb_back (
  input  nnsb_pkg::cfg_t       cfg,
  input  nnsb_pkg::mid_item_t  item,
  input  logic                 mid_empty,
  input  logic                 out_full,
  output logic                 mid_pop,
  output logic                 out_push,
  output nnsb_pkg::res_item_t  res
);
  import nnsb_pkg::*;

  localparam int PROD_W = INT_BITS + PITCH_W;

  logic [PROD_W-1:0]    fetch_prod;
  logic [INT_BITS+1:0]  sx_scaled;
  logic [PROD_W-1:0]    write_prod;
  logic [IDX_W+1:0]     col_scaled;
  logic [ADDR_W-1:0]    fetch_sum;
  logic [ADDR_W-1:0]    write_sum;

  // move one item whenever the middle queue holds one and the result queue has room
  assign mid_pop  = !mid_empty && !out_full;
  assign out_push = mid_pop;

  // source address: row times pitch plus column times pixel size
  assign fetch_prod = PROD_W'(item.sy) * PROD_W'(cfg.src_pitch);
  assign sx_scaled  = cfg.bpp4 ? {item.sx, 2'b00}
                                : ({1'b0, item.sx, 1'b0} + {2'b00, item.sx});
  assign fetch_sum  = ADDR_W'(fetch_prod) + ADDR_W'(sx_scaled);

  // destination address with flipped row
  assign write_prod = PROD_W'(item.flipped) * PROD_W'(cfg.dst_pitch);
  assign col_scaled = cfg.out16 ? {1'b0, item.col, 1'b0} : {item.col, 2'b00};
  assign write_sum  = ADDR_W'(write_prod) + ADDR_W'(col_scaled);

  // result fields, zero where not valid
  always_comb begin
    res              = '0;
    res.fetch_valid  = item.fetch_valid;
    res.pixel_valid  = item.pixel_valid;
    if (item.fetch_valid) begin
      res.fetch_addr = fetch_sum;
    end
    if (item.pixel_valid) begin
      res.write_addr   = write_sum;
      res.packed_pixel = item.packed_pixel;
      res.frame_last   = item.last;
    end
  end

endmodule

// File: hw/rtl/nearest_neighbor_scale_blit_unit.sv
// top level of the nearest-neighbor scale blitter
// depends on nnsb_pkg, nnsb_cfg, nnsb_front, nnsb_fifo, nnsb_back, assert_macros.svh
//
//  channel   handshake          payload
//  --------  -----------------  -----------------------------------------------
//  input     push / full        cmd, byte0, byte1, byte2, byte3
//  result    empty / pop        fetch_valid, fetch_addr, pixel_valid,
//                               write_addr, packed_pixel, frame_last
//  config    cfg_write          cfg_addr, cfg_data
//
//  one item per clock while results are popped; each item gives exactly one result
//  accepted items pass the middle queue, then the result queue, to the result ports
//  the front walks the raster as items are accepted, the back forms both addresses
//  full rises only when the middle queue fills behind a stalled result queue
//  synchronous reset clears the walk, both queues and loads the default config
`include "assert_macros.svh"

module nearest_neighbor_scale_blit_unit #(
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic                              cmd,
  input  logic [7:0]                        byte0,
  input  logic [7:0]                        byte1,
  input  logic [7:0]                        byte2,
  input  logic [7:0]                        byte3,
  output logic                              empty,
  input  logic                              pop,
  output logic                              fetch_valid,
  output logic [nnsb_pkg::ADDR_W-1:0]       fetch_addr,
  output logic                              pixel_valid,
  output logic [nnsb_pkg::ADDR_W-1:0]       write_addr,
  output logic [nnsb_pkg::PIX_W-1:0]        packed_pixel,
  output logic                              frame_last,
  input  logic                              cfg_write,
  input  logic [nnsb_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [nnsb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import nnsb_pkg::*;

  cfg_t      cfg;
  mid_item_t front_item;
  mid_item_t mid_head;
  res_item_t back_res;
  res_item_t out_head;
  logic      accept;
  logic      mid_empty;
  logic      mid_pop;
  logic      out_full;
  logic      out_push;

  assign accept = push && !full;

  // configuration registers
  nnsb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // raster walk and classification
  nnsb_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .cmd    (cmd),
    .byte0  (byte0),
    .byte1  (byte1),
    .byte2  (byte2),
    .byte3  (byte3),
    .item   (front_item)
  );

  // queue between front and back
  nnsb_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (front_item),
    .full  (full),
    .pop   (mid_pop),
    .rdata (mid_head),
    .empty (mid_empty)
  );

  // address generation
  nnsb_back u_back (
    .cfg       (cfg),
    .item      (mid_head),
    .mid_empty (mid_empty),
    .out_full  (out_full),
    .mid_pop   (mid_pop),
    .out_push  (out_push),
    .res       (back_res)
  );

  // result queue
  nnsb_fifo #(
    .WIDTH ($bits(res_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (back_res),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_head),
    .empty (empty)
  );

  assign fetch_valid  = out_head.fetch_valid;
  assign fetch_addr   = out_head.fetch_addr;
  assign pixel_valid  = out_head.pixel_valid;
  assign write_addr   = out_head.write_addr;
  assign packed_pixel = out_head.packed_pixel;
  assign frame_last   = out_head.frame_last;

  // checks
  `ASSERT_IMPLIES(a_last_ends_frame, clk, rst, !empty && frame_last, pixel_valid && !fetch_valid)
  `ASSERT_IMPLIES(a_no_fetch_zero_addr, clk, rst, !empty && !fetch_valid, fetch_addr == '0)
  `ASSERT_IMPLIES(a_back_stalls_on_full, clk, rst, out_full, !mid_pop && !out_push)

endmodule
